// ===== src/assert_macros.svh =====
// concurrent assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// expression holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(label, expr, msg)
`define ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ===== src/ptw_pkg.sv =====
`timescale 1ns / 1ps

package ptw_pkg;

    localparam int ADDR_W         = 52;
    localparam int PHYS_ADDR_BITS = 52;
    localparam int VIRT_W         = 57;
    localparam int ENTRY_W        = 64;
    localparam int LEVEL_W        = 3;
    localparam int IDX_W          = 9;
    localparam int CFG_DATA_W     = 64;
    localparam int CFG_ADDR_W     = 4;

    localparam int PRESENT_POS = 0;
    localparam int HUGE_POS    = 7;

    localparam logic [ADDR_W-1:0] PHYS_MASK  = {ADDR_W{1'b1}} >> (ADDR_W - PHYS_ADDR_BITS);
    localparam logic [ADDR_W-1:0] FRAME_MASK = {{(ADDR_W-12){1'b1}}, {12{1'b0}}};

    localparam logic [LEVEL_W-1:0] LEVEL_FOUR = 3'd4;
    localparam logic [LEVEL_W-1:0] LEVEL_FIVE = 3'd5;

    typedef enum logic {
        OP_START = 1'b0,
        OP_ENTRY = 1'b1
    } t_opcode;

    // register select taken from paddr[3]
    localparam logic REG_ROOT = 1'b0;
    localparam logic REG_FIVE = 1'b1;

    typedef struct packed {
        logic                busy;
        logic [LEVEL_W-1:0]  level;
        logic [VIRT_W-1:0]   virt;
    } t_walk;

    typedef struct packed {
        logic               done;
        logic [ADDR_W-1:0]  read_addr;
        logic [ADDR_W-1:0]  phys_addr;
        logic               not_mapped;
    } t_result;

endpackage

// ===== src/ptw_step.sv =====
`timescale 1ns / 1ps

module ptw_step (
    input  ptw_pkg::t_walk                   i_walk,
    input  logic                             i_opcode,
    input  logic [ptw_pkg::VIRT_W-1:0]       i_virt_addr,
    input  logic [ptw_pkg::ENTRY_W-1:0]      i_entry_data,
    input  logic [ptw_pkg::ADDR_W-1:0]       i_root,
    input  logic                             i_five_level,
    output ptw_pkg::t_walk                   o_walk,
    output logic                             o_emit,
    output ptw_pkg::t_result                 o_res
);
    import ptw_pkg::*;

    // 9-bit table index for a level, levels clamped to 1..5
    function automatic logic [IDX_W-1:0] slot_index(input logic [VIRT_W-1:0] virt,
                                                    input logic [LEVEL_W-1:0] lvl);
        case (lvl) inside
            [3'd0:3'd1]: slot_index = virt[20:12];
            3'd2:        slot_index = virt[29:21];
            3'd3:        slot_index = virt[38:30];
            3'd4:        slot_index = virt[47:39];
            default:     slot_index = virt[56:48];
        endcase
    endfunction

    // offset bits below the page span of a level
    function automatic logic [ADDR_W-1:0] span_mask(input logic [LEVEL_W-1:0] lvl);
        case (lvl) inside
            [3'd0:3'd1]: span_mask = {{(ADDR_W-12){1'b0}}, {12{1'b1}}};
            3'd2:        span_mask = {{(ADDR_W-21){1'b0}}, {21{1'b1}}};
            3'd3:        span_mask = {{(ADDR_W-30){1'b0}}, {30{1'b1}}};
            3'd4:        span_mask = {{(ADDR_W-39){1'b0}}, {39{1'b1}}};
            default:     span_mask = {{(ADDR_W-48){1'b0}}, {48{1'b1}}};
        endcase
    endfunction

    logic [LEVEL_W-1:0] start_level;
    logic [LEVEL_W-1:0] down_level;
    logic [ADDR_W-1:0]  frame;
    logic [ADDR_W-1:0]  low_mask;
    logic [ADDR_W-1:0]  start_addr;
    logic [ADDR_W-1:0]  down_addr;
    logic [ADDR_W-1:0]  leaf_addr;
    logic               present;
    logic               leaf;

    assign start_level = i_five_level ? LEVEL_FIVE : LEVEL_FOUR;
    assign down_level  = LEVEL_W'(i_walk.level - 3'd1);
    assign frame       = i_entry_data[ADDR_W-1:0] & FRAME_MASK & PHYS_MASK;
    assign low_mask    = span_mask(i_walk.level);
    assign present     = i_entry_data[PRESENT_POS];
    assign leaf        = (i_walk.level <= 3'd1) || i_entry_data[HUGE_POS];

    assign start_addr = ((i_root & PHYS_MASK)
                        + {{(ADDR_W-IDX_W-3){1'b0}}, slot_index(i_virt_addr, start_level), 3'b000})
                        & PHYS_MASK;
    assign down_addr  = (frame
                        + {{(ADDR_W-IDX_W-3){1'b0}}, slot_index(i_walk.virt, down_level), 3'b000})
                        & PHYS_MASK;
    assign leaf_addr  = ((frame & ~low_mask) + (i_walk.virt[ADDR_W-1:0] & low_mask)) & PHYS_MASK;

    always_comb begin
        o_walk = i_walk;
        o_emit = 1'b0;
        o_res  = '0;
        if (i_opcode == OP_START) begin
            // a start abandons any walk in flight
            o_walk.busy      = 1'b1;
            o_walk.level     = start_level;
            o_walk.virt      = i_virt_addr;
            o_emit           = 1'b1;
            o_res.read_addr  = start_addr;
        end else if (i_walk.busy) begin
            o_emit = 1'b1;
            if (!present) begin
                o_walk.busy      = 1'b0;
                o_res.done       = 1'b1;
                o_res.not_mapped = 1'b1;
            end else if (leaf) begin
                o_walk.busy      = 1'b0;
                o_res.done       = 1'b1;
                o_res.phys_addr  = leaf_addr;
            end else begin
                o_walk.level     = down_level;
                o_res.read_addr  = down_addr;
            end
        end
    end

endmodule

// ===== src/page_table_walker.sv =====
`timescale 1ns / 1ps
// page table walker, four or five levels of 64-bit entries
// input channel (i_in_valid / o_in_stall) carries one item per transfer: a start
// (i_opcode 0, i_virt_addr) or a table entry read back from memory (i_opcode 1,
// i_entry_data). output channel (o_out_valid / i_out_stall) returns one item per
// step: a read request for o_read_addr (o_done_res 0) or the end of the walk with
// o_phys_addr and o_not_mapped (o_done_res 1). an entry that arrives with no walk
// in flight is dropped and gives no item; a start during a walk restarts it.
// from input acceptance to o_out_valid there is one input register and one result
// register, with the slice, mask and 52-bit add logic between them.
// throughput is one item per cycle while the output is not stalled; the caller
// must return each entry before the next step of the same walk can be computed.
// when the output is stalled the result register holds, then the input register
// fills and o_in_stall rises; nothing is dropped.
// the apb port writes root_table_addr at 0x0 and five_level at 0x8 (64-bit data);
// write them only while no walk is in flight.
// synchronous active-low reset empties both registers, ends any walk and clears
// the configuration to zero.
`include "assert_macros.svh"

module page_table_walker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_opcode,
    input  logic [ptw_pkg::VIRT_W-1:0]         i_virt_addr,
    input  logic [ptw_pkg::ENTRY_W-1:0]        i_entry_data,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_done_res,
    output logic [ptw_pkg::ADDR_W-1:0]         o_read_addr,
    output logic [ptw_pkg::ADDR_W-1:0]         o_phys_addr,
    output logic                               o_not_mapped,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ptw_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [ptw_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [ptw_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                               pready
);
    import ptw_pkg::*;

    logic                r_in_valid;
    logic                r_in_opcode;
    logic [VIRT_W-1:0]   r_in_virt;
    logic [ENTRY_W-1:0]  r_in_entry;

    logic                r_out_valid;
    t_result             r_out;

    t_walk               r_walk;
    t_walk               n_walk;
    logic                step_emit;
    t_result             step_res;

    logic [ADDR_W-1:0]   r_root;
    logic                r_five;

    logic                out_blocked;
    logic                advance;
    logic                cfg_write;

    assign out_blocked = r_out_valid && i_out_stall;
    assign advance     = r_in_valid && !out_blocked;
    assign o_in_stall  = r_in_valid && out_blocked;
    assign cfg_write   = psel && penable && pwrite && pready;
    assign pready      = 1'b1;

    ptw_step u_step (
        .i_walk       (r_walk),
        .i_opcode     (r_in_opcode),
        .i_virt_addr  (r_in_virt),
        .i_entry_data (r_in_entry),
        .i_root       (r_root),
        .i_five_level (r_five),
        .o_walk       (n_walk),
        .o_emit       (step_emit),
        .o_res        (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_opcode <= i_opcode;
            r_in_virt   <= i_virt_addr;
            r_in_entry  <= i_entry_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_walk      <= '0;
        end else begin
            if (!out_blocked) begin
                r_out_valid <= advance && step_emit;
            end
            if (advance) begin
                r_walk <= n_walk;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && step_emit) begin
            r_out <= step_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root <= '0;
            r_five <= 1'b0;
        end else if (cfg_write) begin
            case (paddr[3])
                REG_ROOT: r_root <= pwdata[ADDR_W-1:0];
                REG_FIVE: r_five <= pwdata[0];
                default:  r_five <= r_five;
            endcase
        end
    end

    always_comb begin
        case (paddr[3])
            REG_ROOT: prdata = {{(CFG_DATA_W-ADDR_W){1'b0}}, r_root};
            REG_FIVE: prdata = {{(CFG_DATA_W-1){1'b0}}, r_five};
            default:  prdata = '0;
        endcase
    end

    assign o_out_valid  = r_out_valid;
    assign o_done_res   = r_out.done;
    assign o_read_addr  = r_out.read_addr;
    assign o_phys_addr  = r_out.phys_addr;
    assign o_not_mapped = r_out.not_mapped;

    `ASSERT_NEXT(a_done_ends_walk, advance && step_emit && step_res.done, !r_walk.busy,
        "walk still busy after a finishing step")
    `ASSERT_NEXT(a_request_keeps_walk, advance && step_emit && !step_res.done, r_walk.busy,
        "read request issued without a walk in flight")
    `ASSERT_ALWAYS(a_busy_level_range,
        !r_walk.busy || (r_walk.level != 3'd0 && r_walk.level <= LEVEL_FIVE),
        "walk level out of range while busy")
    `ASSERT_ALWAYS(a_done_no_request, !r_out_valid || !r_out.done || r_out.read_addr == '0,
        "finished walk carries a read address")

endmodule
